// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: field widths, operation and status
// codes, controller states and the structs passed along the row of cells.
// No dependencies.
package spq_pkg;

    localparam int SPQ_DEPTH = 64;
    localparam int ID_W      = 16;
    localparam int PRIO_W    = 32;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CHANGE = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RESOLVE,
        S_INSERT,
        S_OUT
    } t_state;

    // Command broadcast to every cell
    typedef enum logic [1:0] {
        CC_HOLD,
        CC_SCAN,
        CC_REMOVE,
        CC_INSERT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd          cmd;
        logic               rem_all;  // remove shifts every cell (pop)
        logic               use_ge;   // stable placement after a removal
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
    } t_cell_ctl;

    // What a cell shows its neighbors and the controller
    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic               gt;       // entry sorts after the broadcast word
        logic               match;    // entry id equals the broadcast id
        logic               s_hit;    // an earlier cell matched
        logic [PRIO_W-1:0]  s_pr;     // priority of that earliest match
    } t_cell_out;

endpackage

// ===== rtl/spq_if.sv =====
// Valid/ready channel interfaces for the sorted priority queue.
// Depends on spq_pkg for field widths.
interface spq_in_if;
    import spq_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, op, id, priority_req, input ready);
    modport sink   (input valid, op, id, priority_req, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              found;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_priority;
    logic [CNT_W-1:0]  count;
    logic [ID_W-1:0]   head_id;
    logic [PRIO_W-1:0] head_priority;

    modport source (output valid, status, found, out_id, out_priority, count,
                    head_id, head_priority, input ready);
    modport sink   (input valid, status, found, out_id, out_priority, count,
                    head_id, head_priority, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its
// neighbors on insert and remove; carries the first-match scan one step.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_cell_out i_left,
    input  t_cell_out i_right,
    output t_cell_out o_cell
);

    logic              r_valid, n_valid;
    logic [ID_W-1:0]   r_id, n_id;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic              r_ge, n_ge;
    logic              r_s_hit, n_s_hit;
    logic [PRIO_W-1:0] r_s_pr, n_s_pr;

    logic w_gt;
    logic w_match;
    logic w_rm;

    // Compare against the broadcast word
    assign w_gt    = r_valid && ((r_prio > i_ctl.prio) ||
                     (i_ctl.use_ge && r_ge && (r_prio == i_ctl.prio)));
    assign w_match = r_valid && (r_id == i_ctl.id);
    assign w_rm    = i_ctl.rem_all || r_s_hit || w_match;

    // Next entry and scan state
    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_prio  = r_prio;
        n_ge    = r_ge;
        n_s_hit = r_s_hit;
        n_s_pr  = r_s_pr;
        unique case (i_ctl.cmd)
            CC_HOLD: begin
            end
            CC_SCAN: begin
                n_s_hit = i_left.s_hit || i_left.match;
                n_s_pr  = i_left.s_hit ? i_left.s_pr : i_left.prio;
            end
            CC_REMOVE: begin
                // close the gap: cells at or after the removed one pull from the right
                n_ge = w_rm;
                if (w_rm) begin
                    n_valid = i_right.valid;
                    n_id    = i_right.id;
                    n_prio  = i_right.prio;
                end
            end
            CC_INSERT: begin
                // shift right behind the new word, or take the new word
                if (i_left.gt) begin
                    n_valid = 1'b1;
                    n_id    = i_left.id;
                    n_prio  = i_left.prio;
                end else if (w_gt || (!r_valid && i_left.valid)) begin
                    n_valid = 1'b1;
                    n_id    = i_ctl.id;
                    n_prio  = i_ctl.prio;
                end
            end
            default: begin
            end
        endcase
    end

    // Control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ge    <= 1'b0;
            r_s_hit <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_ge    <= n_ge;
            r_s_hit <= n_s_hit;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
        r_s_pr <= n_s_pr;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.id    = r_id;
    assign o_cell.prio  = r_prio;
    assign o_cell.gt    = w_gt;
    assign o_cell.match = w_match;
    assign o_cell.s_hit = r_s_hit;
    assign o_cell.s_pr  = r_s_pr;

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: controller, row of spq_cell slots
// and the output word register. Depends on spq_pkg, spq_if and spq_cell.
//
//  channel  | dir | handshake       | word
//  ---------+-----+-----------------+---------------------------------------------
//  i_in     | in  | valid/ready     | op, id, priority_req
//  o_out    | out | valid/ready     | status, found, out_id, out_priority,
//           |     |                 | count, head_id, head_priority
//
// Insert and pop pass through accept, update of the row and load of the output word.
// Lookup and change run a first-match scan before the output word is loaded; the scan
// moves one cell per cycle down the row of DEPTH cells.
// Reset empties the queue at once; no clearing pass.
// A stalled output word holds; the next word is accepted meanwhile and waits in
// the controller until the output register frees.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
)
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    spq_in_if.sink         i_in,
    spq_out_if.source      o_out
);

    localparam int RCW = $clog2(DEPTH + 1);
    localparam int SCW = $clog2(DEPTH);
    localparam logic [SCW-1:0] LAST_STEP = SCW'(DEPTH - 2);
    localparam t_cell_out LEFT_EDGE  = '{valid: 1'b1, default: '0};
    localparam t_cell_out RIGHT_EDGE = '0;

    t_state            r_state, n_state;
    t_op               r_op;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic [RCW-1:0]    r_count;
    logic [SCW-1:0]    r_scan_cnt;

    t_status           r_res_status;
    logic              r_res_found;
    logic [ID_W-1:0]   r_res_id;
    logic [PRIO_W-1:0] r_res_prio;

    logic              r_out_valid;
    t_status           r_out_status;
    logic              r_out_found;
    logic [ID_W-1:0]   r_out_id;
    logic [PRIO_W-1:0] r_out_prio;
    logic [CNT_W-1:0]  r_out_count;
    logic [ID_W-1:0]   r_out_head_id;
    logic [PRIO_W-1:0] r_out_head_prio;

    t_cell_ctl         w_ctl;
    t_cell_out         c [DEPTH];

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_out_free;
    logic              w_found;
    logic [PRIO_W-1:0] w_found_prio;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == RCW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_out_valid || o_out.ready;

    // Scan result at the tail of the row
    assign w_found      = c[DEPTH-1].s_hit || c[DEPTH-1].match;
    assign w_found_prio = c[DEPTH-1].s_hit ? c[DEPTH-1].s_pr : c[DEPTH-1].prio;

    // Row of cells
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_cell_out w_left, w_right;
        if (k == 0) begin : g_first
            assign w_left = LEFT_EDGE;
        end else begin : g_mid_l
            assign w_left = c[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = RIGHT_EDGE;
        end else begin : g_mid_r
            assign w_right = c[k+1];
        end
        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_cell  (c[k])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_accept) n_state = S_DECODE;
            S_DECODE: begin
                if (r_op == OP_INSERT || r_op == OP_POP) n_state = S_OUT;
                else                                      n_state = S_SCAN;
            end
            S_SCAN:    if (r_scan_cnt == LAST_STEP) n_state = S_RESOLVE;
            S_RESOLVE: begin
                if (r_op == OP_CHANGE && w_found) n_state = S_INSERT;
                else                              n_state = S_OUT;
            end
            S_INSERT:  n_state = S_OUT;
            S_OUT:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Controller outputs: cell command and input ready
    always_comb begin
        w_ctl.cmd     = CC_HOLD;
        w_ctl.rem_all = 1'b0;
        w_ctl.use_ge  = 1'b0;
        w_ctl.id      = r_id;
        w_ctl.prio    = r_prio;
        unique case (r_state)
            S_DECODE: begin
                if (r_op == OP_INSERT && !w_full) begin
                    w_ctl.cmd = CC_INSERT;
                end else if (r_op == OP_POP && !w_empty) begin
                    w_ctl.cmd     = CC_REMOVE;
                    w_ctl.rem_all = 1'b1;
                end
            end
            S_SCAN:    w_ctl.cmd = CC_SCAN;
            S_RESOLVE: if (r_op == OP_CHANGE && w_found) w_ctl.cmd = CC_REMOVE;
            S_INSERT: begin
                w_ctl.cmd    = CC_INSERT;
                w_ctl.use_ge = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    // State, count and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_scan_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECODE) begin
                r_scan_cnt <= '0;
                if (r_op == OP_INSERT && !w_full)      r_count <= r_count + RCW'(1);
                else if (r_op == OP_POP && !w_empty)   r_count <= r_count - RCW'(1);
            end else if (r_state == S_SCAN) begin
                r_scan_cnt <= r_scan_cnt + SCW'(1);
            end
        end
    end

    // Latch the request word and build the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= t_op'(i_in.op);
            r_id   <= i_in.id;
            r_prio <= i_in.priority_req;
        end
        if (r_state == S_DECODE) begin
            r_res_status <= ST_OK;
            r_res_found  <= 1'b0;
            r_res_id     <= '0;
            r_res_prio   <= '0;
            if (r_op == OP_INSERT && w_full) begin
                r_res_status <= ST_FULL;
            end else if (r_op == OP_POP) begin
                if (w_empty) begin
                    r_res_status <= ST_EMPTY;
                end else begin
                    r_res_id   <= c[0].id;
                    r_res_prio <= c[0].prio;
                end
            end
        end else if (r_state == S_RESOLVE) begin
            if (!w_found) begin
                r_res_status <= ST_NOT_FOUND;
            end else if (r_op == OP_LOOKUP) begin
                r_res_found <= 1'b1;
                r_res_id    <= r_id;
                r_res_prio  <= w_found_prio;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_status    <= r_res_status;
            r_out_found     <= r_res_found;
            r_out_id        <= r_res_id;
            r_out_prio      <= r_res_prio;
            r_out_count     <= CNT_W'(r_count);
            r_out_head_id   <= c[0].valid ? c[0].id   : '0;
            r_out_head_prio <= c[0].valid ? c[0].prio : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.found         = r_out_found;
    assign o_out.out_id        = r_out_id;
    assign o_out.out_priority  = r_out_prio;
    assign o_out.count         = r_out_count;
    assign o_out.head_id       = r_out_head_id;
    assign o_out.head_priority = r_out_head_prio;

    // Count never passes the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RCW'(DEPTH))
        else $error("entry count above depth");

    // Last cell is occupied exactly when the queue is full, except while a
    // changed entry is out of the row
    a_tail_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INSERT) |-> (c[DEPTH-1].valid == w_full))
        else $error("tail occupancy disagrees with count");

    // After an insert the head sorts no later than the new word
    a_insert_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE && r_op == OP_INSERT && !w_full)
        |=> (c[0].valid && c[0].prio <= $past(r_prio)))
        else $error("insert left head above new priority");

    // A change re-sorts and keeps the count
    a_change_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |=> (r_count == $past(r_count)))
        else $error("change altered entry count");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue_top: offers insert, pop, change and lookup
// words, predicts every output word with a sorted list of its own and checks it.
// Depends on spq_pkg, spq_if and sorted_priority_queue_top.
module testbench;
    import spq_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int HOLD_OFF   = 400;
    localparam int TAIL_WAIT  = SPQ_DEPTH + 8;
    localparam int PEND_DEPTH = 8;

    typedef struct {
        t_status           status;
        logic              found;
        logic [ID_W-1:0]   out_id;
        logic [PRIO_W-1:0] out_priority;
        logic [CNT_W-1:0]  count;
        logic [ID_W-1:0]   head_id;
        logic [PRIO_W-1:0] head_priority;
    } t_word;

    logic i_clk;
    logic i_rst_n;

    spq_in_if  in_if ();
    spq_out_if out_if ();

    sorted_priority_queue_top #(.DEPTH(SPQ_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted queue contents, kept in ascending priority order
    logic [ID_W-1:0]   slot_id   [SPQ_DEPTH];
    logic [PRIO_W-1:0] slot_prio [SPQ_DEPTH];
    int                fill_level;

    // Predicted words in flight: the sender advances pend_wr, the checker pend_rd
    t_word pending_words [PEND_DEPTH];
    int    pend_wr;
    int    pend_rd;
    int    error_count;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_left;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("sorted_priority_queue_top test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Queue prediction
    // ---------------------------------------------------------------
    function automatic void drop_slot(int pos);
        for (int k = pos; k + 1 < fill_level; k++) begin
            slot_id[k]   = slot_id[k + 1];
            slot_prio[k] = slot_prio[k + 1];
        end
        fill_level--;
    endfunction

    function automatic void place_slot(int pos, logic [ID_W-1:0] id,
                                       logic [PRIO_W-1:0] prio);
        for (int k = fill_level; k > pos; k--) begin
            slot_id[k]   = slot_id[k - 1];
            slot_prio[k] = slot_prio[k - 1];
        end
        slot_id[pos]   = id;
        slot_prio[pos] = prio;
        fill_level++;
    endfunction

    function automatic int first_slot(logic [ID_W-1:0] id);
        for (int k = 0; k < fill_level; k++)
            if (slot_id[k] == id) return k;
        return -1;
    endfunction

    // Apply one operation to the predicted queue and build its output word
    function automatic t_word predict_result(t_op op, logic [ID_W-1:0] id,
                                             logic [PRIO_W-1:0] prio);
        t_word w;
        int    pos;
        int    j;
        w.status       = ST_OK;
        w.found        = 1'b0;
        w.out_id       = '0;
        w.out_priority = '0;
        case (op)
            OP_INSERT: begin
                if (fill_level >= SPQ_DEPTH) begin
                    w.status = ST_FULL;
                end else begin
                    j = 0;
                    while (j < fill_level && slot_prio[j] <= prio) j++;
                    place_slot(j, id, prio);
                end
            end
            OP_POP: begin
                if (fill_level == 0) begin
                    w.status = ST_EMPTY;
                end else begin
                    w.out_id       = slot_id[0];
                    w.out_priority = slot_prio[0];
                    drop_slot(0);
                end
            end
            OP_CHANGE: begin
                pos = first_slot(id);
                if (pos < 0) begin
                    w.status = ST_NOT_FOUND;
                end else begin
                    drop_slot(pos);
                    // stable placement: equal priorities that stood behind stay behind
                    j = 0;
                    while (j < fill_level) begin
                        if (slot_prio[j] > prio || (slot_prio[j] == prio && j >= pos)) break;
                        j++;
                    end
                    place_slot(j, id, prio);
                end
            end
            default: begin
                pos = first_slot(id);
                if (pos < 0) begin
                    w.status = ST_NOT_FOUND;
                end else begin
                    w.found        = 1'b1;
                    w.out_id       = slot_id[pos];
                    w.out_priority = slot_prio[pos];
                end
            end
        endcase
        w.count         = CNT_W'(fill_level);
        w.head_id       = (fill_level != 0) ? slot_id[0] : '0;
        w.head_priority = (fill_level != 0) ? slot_prio[0] : '0;
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_word(t_op op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
        // idle a random number of cycles before offering
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid        <= 1'b1;
        in_if.op           <= op;
        in_if.id           <= id;
        in_if.priority_req <= prio;
        do @(posedge i_clk); while (!in_if.ready);
        pending_words[pend_wr % PEND_DEPTH] = predict_result(op, id, prio);
        pend_wr++;
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic wait_drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pend_wr != pend_rd) @(posedge i_clk);
    endtask

    // Mostly ids already queued or from a small pool, so lookups and changes hit
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 60 && fill_level > 0) return slot_id[$urandom_range(fill_level - 1)];
        if (r < 85) return ID_W'($urandom_range(15));
        return ID_W'($urandom_range(16'hFFFF));
    endfunction

    // Favor repeated priorities to exercise the stable ordering
    function automatic logic [PRIO_W-1:0] pick_prio();
        int r;
        r = $urandom_range(99);
        if (r < 15 && fill_level > 0) return slot_prio[$urandom_range(fill_level - 1)];
        if (r < 25) return '0;
        if (r < 32) return '1;
        if (r < 55) return {16'($urandom_range(7)), 16'h0000};
        return $urandom();
    endfunction

    // ---------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic void check_field(string name, logic [PRIO_W-1:0] want,
                                        logic [PRIO_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Compare each accepted output word with the oldest prediction
    always @(posedge i_clk) begin : check_out
        t_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pend_wr == pend_rd) begin
                $display("%0t: output word with none expected, expected none, actual count %0d",
                         $time, out_if.count);
                error_count++;
            end else begin
                want = pending_words[pend_rd % PEND_DEPTH];
                pend_rd++;
                check_field("status", PRIO_W'(want.status), PRIO_W'(out_if.status));
                check_field("found", PRIO_W'(want.found), PRIO_W'(out_if.found));
                check_field("out_id", PRIO_W'(want.out_id), PRIO_W'(out_if.out_id));
                check_field("out_priority", want.out_priority, out_if.out_priority);
                check_field("count", PRIO_W'(want.count), PRIO_W'(out_if.count));
                check_field("head_id", PRIO_W'(want.head_id), PRIO_W'(out_if.head_id));
                check_field("head_priority", want.head_priority, out_if.head_priority);
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Empty-queue flags, field extremes, duplicates and stable re-sorting
    task automatic test_directed();
        send_word(OP_POP, 16'h0000, 32'h0000_0000);
        send_word(OP_LOOKUP, 16'h1234, 32'h0000_0000);
        send_word(OP_CHANGE, 16'h1234, 32'h0001_0000);
        send_word(OP_INSERT, 16'h0000, 32'h0000_0000);
        send_word(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 16'h0000, 32'h0000_0000);
        send_word(OP_INSERT, 16'h00AA, 32'h0001_8000);
        send_word(OP_INSERT, 16'h5555, 32'hFFFF_FFFF);
        send_word(OP_LOOKUP, 16'h0000, 32'hAAAA_5555);
        send_word(OP_LOOKUP, 16'hFFFF, 32'h0000_0000);
        send_word(OP_CHANGE, 16'h0000, 32'hFFFF_FFFF);
        send_word(OP_CHANGE, 16'hFFFF, 32'h0000_0000);
        send_word(OP_CHANGE, 16'h00AA, 32'h0001_8000);
        send_word(OP_CHANGE, 16'h5555, 32'h0001_8000);
        send_word(OP_LOOKUP, 16'h5555, 32'h5555_AAAA);
        repeat (5) send_word(OP_POP, 16'hA5A5, 32'h5A5A_A5A5);
        send_word(OP_POP, 16'h0000, 32'h0000_0000);
        wait_drain();
    endtask

    // Fill to capacity behind a long receiver stall, hit the full flag, then empty it
    task automatic test_fill_and_stall();
        hold_left = HOLD_OFF;
        while (fill_level < SPQ_DEPTH) send_word(OP_INSERT, pick_id(), pick_prio());
        repeat (3) send_word(OP_INSERT, pick_id(), pick_prio());
        repeat (3) send_word(OP_LOOKUP, pick_id(), pick_prio());
        repeat (3) send_word(OP_CHANGE, pick_id(), pick_prio());
        while (fill_level > 0) send_word(OP_POP, pick_id(), pick_prio());
        send_word(OP_POP, pick_id(), pick_prio());
        wait_drain();
    endtask

    // Mixed operations, steering the fill level away from both ends
    task automatic test_random_mix(int n_words);
        int r;
        int ins_pct;
        t_op op;
        for (int i = 0; i < n_words; i++) begin
            r       = $urandom_range(99);
            ins_pct = (fill_level < 8) ? 50 : (fill_level > 48) ? 15 : 30;
            if (r < ins_pct)           op = OP_INSERT;
            else if (r < ins_pct + 20) op = OP_POP;
            else if (r < ins_pct + 45) op = OP_CHANGE;
            else                       op = OP_LOOKUP;
            send_word(op, pick_id(), pick_prio());
        end
        wait_drain();
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.op           = OP_INSERT;
        in_if.id           = '0;
        in_if.priority_req = '0;
        i_rst_n            = 1'b0;
        error_count        = 0;
        fill_level         = 0;
        pend_wr            = 0;
        pend_rd            = 0;
        hold_left          = 0;
        send_idle_pct      = 22;
        recv_idle_pct      = 74;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_and_stall();
        test_random_mix(230);

        send_idle_pct = 74;
        recv_idle_pct = 22;
        test_random_mix(230);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(230);

        // let any stray word show up before the verdict
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (error_count == 0 && pend_wr == pend_rd) begin
            $display("sorted_priority_queue_top test passed");
        end else begin
            $display("sorted_priority_queue_top test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
test/testbench.sv
